>>> hdl/isort_pkg.sv
// ---------------------------------------------------------------------------
// isort_pkg
// Shared types and constants for the integer sorter cell chain.
// ---------------------------------------------------------------------------
package isort_pkg;

   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   // Broadcast from the sequencer to every cell.
   typedef struct packed {
      logic     insert;   // place new value into the sorted chain
      logic     shift;    // move every cell one place toward the head
      data_type value;    // value being inserted
   } ctl_type;

endpackage

>>> hdl/isort_cell.sv
// ---------------------------------------------------------------------------
// isort_cell
// One slot of the sorted chain: holds a value and a valid bit, and on insert
// either keeps its value, takes the left neighbor's or takes the new one; on shift it takes the right neighbor's.
// ---------------------------------------------------------------------------
module isort_cell
   import isort_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  ctl_type  ctl,
   input  data_type left_value,
   input  logic     left_valid,
   input  logic     left_gt,
   input  data_type right_value,
   input  logic     right_valid,
   output data_type value,
   output logic     valid,
   output logic     gt
);

   data_type value_ff, value_in;
   logic     valid_ff, valid_in;

   // Empty slots compare greater than anything, so the insert point is the
   // first slot whose flag is set.
   assign gt = !valid_ff || (value_ff > ctl.value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.shift) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (ctl.insert && gt) begin
         if (left_gt) begin
            value_in = left_value;
            valid_in = left_valid;
         end else begin
            value_in = ctl.value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

>>> hdl/integer_sorter_top.sv
// ---------------------------------------------------------------------------
// integer_sorter_top
// Ascending sorter for sets of signed 32-bit values, built as a cell chain.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one signed value per request; req_tlast closes the set.
//   Each request is placed straight into its sorted position in the chain of
//   MAX_ITEMS cells, one request per cycle while loading.
//   Requests past MAX_ITEMS in a set are dropped; every response of that set
//   then has rsp_tuser set.
//   rsp channel: after the closing request the set streams out smallest
//   first, one per cycle when rsp_tready is high, rsp_tlast on the largest.
//   The first response is valid the cycle after the closing request is taken.
//   A set is loaded, then drained; the drain is limited by the single head
//   cell that feeds rsp_tdata.
//   req_tready is low while a set drains. A stalled receiver simply holds the
//   head cell; nothing is lost.
//   Reset: synchronous, clears all valid bits, the drop flag and the
//   sequencer; the block is ready for requests the cycle after.
// ---------------------------------------------------------------------------
module integer_sorter_top
   import isort_pkg::*;
#(
   parameter int MAX_ITEMS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast,
   output logic        rsp_tuser    // [0] overflow
);

   state_type state_ff, state_in;
   logic      dropped_ff, dropped_in;
   ctl_type   ctl;

   data_type  cell_value [MAX_ITEMS];
   logic      cell_valid [MAX_ITEMS];
   logic      cell_gt    [MAX_ITEMS];

   logic req_hs, rsp_hs, full;

   assign full   = cell_valid[MAX_ITEMS-1];
   assign req_hs = req_tvalid && req_tready;
   assign rsp_hs = rsp_tvalid && rsp_tready;

   always_comb begin
      state_in   = state_ff;
      dropped_in = dropped_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      ctl.insert = 1'b0;
      ctl.shift  = 1'b0;
      ctl.value  = data_type'(req_tdata);
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_hs) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  ctl.insert = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            rsp_tvalid = 1'b1;
            if (rsp_hs) begin
               ctl.shift = 1'b1;
               if (!cell_valid[1]) begin
                  state_in   = ST_LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      data_type lv, rv;
      logic     lval, lgt, rval;
      if (i == 0) begin : g_head
         assign lv   = '0;
         assign lval = 1'b1;
         assign lgt  = 1'b0;
      end else begin : g_body
         assign lv   = cell_value[i-1];
         assign lval = cell_valid[i-1];
         assign lgt  = cell_gt[i-1];
      end
      if (i == MAX_ITEMS-1) begin : g_tail
         assign rv   = '0;
         assign rval = 1'b0;
      end else begin : g_inner
         assign rv   = cell_value[i+1];
         assign rval = cell_valid[i+1];
      end
      isort_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_value  (lv),
         .left_valid  (lval),
         .left_gt     (lgt),
         .right_value (rv),
         .right_valid (rval),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .gt          (cell_gt[i])
      );
   end

   assign rsp_tdata = 32'(cell_value[0]);
   assign rsp_tlast = !cell_valid[1];
   assign rsp_tuser = dropped_ff;

endmodule

>>> hdl/isort_checker.sv
// ---------------------------------------------------------------------------
// isort_checker
// Port-level checks for the integer sorter, bound to the top level.
// ---------------------------------------------------------------------------
module isort_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // Loading and draining never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while draining");

   a_close_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> rsp_tvalid)
      else $error("closing request did not start drain");

   // Results come out in non-decreasing signed order.
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && ($signed(rsp_tdata) >= $signed($past(rsp_tdata)))))
      else $error("response out of order");

   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid && req_tready))
      else $error("drain did not end after last response");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind integer_sorter_top isort_checker u_isort_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
